// File: rtl/core/shcc_pkg.sv
package shcc_pkg;

   // Field widths of the transactions.
   localparam int LWidth     = 4;
   localparam int MWidth     = 5;
   localparam int TWidth     = 4;
   localparam int UWidth     = 4;
   localparam int VWidth     = 3;
   localparam int MagWidth   = 54;
   localparam int ShiftWidth = 5;

   // Binomial table: n runs to 16 (|m| of minus sixteen), k is folded to at most 8.
   localparam int BinomRows  = 17;
   localparam int BinomCols  = 9;
   localparam int BinomWidth = 14;
   localparam int ArgWidth   = 5;
   localparam int ColWidth   = 4;
   localparam int ProdWidth  = 2 * BinomWidth;

   typedef logic [BinomWidth-1:0] binom_type;
   typedef binom_type [BinomRows-1:0][BinomCols-1:0] binom_table_type;

   // Pascal's triangle, built at elaboration.
   function automatic binom_table_type build_binom_table();
      binom_table_type tab;
      tab = '0;
      for (int n = 0; n < BinomRows; n++) begin
         tab[n][0] = binom_type'(1);
         for (int k = 1; k < BinomCols; k++) begin
            if (n > 0 && k <= n) begin
               tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
            end
         end
      end
      return tab;
   endfunction

   localparam binom_table_type BinomTable = build_binom_table();

   // Micro-operations of the datapath.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_CLEAR_A,
      OP_LOAD_A,
      OP_MUL_A,
      OP_LOAD_B,
      OP_MUL_B,
      OP_MUL_AB,
      OP_DONE
   } op_type;

   // Operand pair fed to the binomial lookup.
   typedef enum logic [1:0] {
      SEL_L_T,
      SEL_DIAG,
      SEL_T_U,
      SEL_M_V
   } sel_type;

   typedef enum logic {
      JMP_NONE,
      JMP_BAD
   } jump_type;

   localparam int StepWidth = 3;
   typedef logic [StepWidth-1:0] step_type;

   localparam step_type StepFirst = 3'd0;
   localparam step_type StepDone  = 3'd6;

   // Control handed from the sequencer to the datapath.
   typedef struct packed {
      op_type  op;
      sel_type sel;
   } ctrl_type;

   typedef struct packed {
      ctrl_type ctrl;
      jump_type jmp;
      step_type target;
   } uword_type;

   // Microprogram: clear, four lookups folded into two partial products, final product.
   function automatic uword_type ucode_rom(input step_type step);
      uword_type w;
      unique case (step)
         3'd0:    w = '{ctrl: '{op: OP_CLEAR_A, sel: SEL_L_T}, jmp: JMP_BAD,  target: StepDone};
         3'd1:    w = '{ctrl: '{op: OP_LOAD_A,  sel: SEL_L_T}, jmp: JMP_NONE, target: StepFirst};
         3'd2:    w = '{ctrl: '{op: OP_MUL_A,   sel: SEL_DIAG}, jmp: JMP_NONE, target: StepFirst};
         3'd3:    w = '{ctrl: '{op: OP_LOAD_B,  sel: SEL_T_U}, jmp: JMP_NONE, target: StepFirst};
         3'd4:    w = '{ctrl: '{op: OP_MUL_B,   sel: SEL_M_V}, jmp: JMP_NONE, target: StepFirst};
         3'd5:    w = '{ctrl: '{op: OP_MUL_AB,  sel: SEL_L_T}, jmp: JMP_NONE, target: StepFirst};
         default: w = '{ctrl: '{op: OP_DONE,    sel: SEL_L_T}, jmp: JMP_NONE, target: StepFirst};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/shcc_datapath.sv
module shcc_datapath
   import shcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic [LWidth-1:0]        ang_l,
   input  logic signed [MWidth-1:0] order_m,
   input  logic [TWidth-1:0]        index_t,
   input  logic [UWidth-1:0]        index_u,
   input  logic [VWidth-1:0]        index_v,
   input  ctrl_type                 ctrl,
   output logic [MagWidth-1:0]      magnitude,
   output logic [ShiftWidth-1:0]    shift_count,
   output logic                     bad
);

   logic [LWidth-1:0]    l_ff, l_in;
   logic [TWidth-1:0]    t_ff, t_in;
   logic [UWidth-1:0]    u_ff, u_in;
   logic [VWidth-1:0]    v_ff, v_in;
   logic [MWidth-1:0]    absm_ff, absm_in;
   logic                 neg_ff, neg_in;
   logic                 bad_ff, bad_in;
   logic [MagWidth-1:0]  acc_a_ff, acc_a_in;
   logic [ProdWidth-1:0] acc_b_ff, acc_b_in;

   logic [ArgWidth-1:0]    n_sel, k_sel, n_minus_k, k_fold;
   binom_type              bin;
   logic [ProdWidth-1:0]   prod_a, prod_b;
   logic [2*ProdWidth-1:0] prod_ab;

   // Operand capture at the start of a transaction.
   always_comb begin
      if (load) begin
         l_in    = ang_l;
         t_in    = index_t;
         u_in    = index_u;
         v_in    = index_v;
         neg_in  = order_m[MWidth-1];
         absm_in = order_m[MWidth-1] ? (MWidth'(0) - $unsigned(order_m)) : $unsigned(order_m);
         bad_in  = index_t > ang_l;
      end else begin
         l_in    = l_ff;
         t_in    = t_ff;
         u_in    = u_ff;
         v_in    = v_ff;
         neg_in  = neg_ff;
         absm_in = absm_ff;
         bad_in  = bad_ff;
      end
   end

   // Operand pair for the binomial lookup.
   always_comb begin
      unique case (ctrl.sel)
         SEL_L_T: begin
            n_sel = ArgWidth'(l_ff);
            k_sel = ArgWidth'(t_ff);
         end
         SEL_DIAG: begin
            n_sel = ArgWidth'(l_ff) - ArgWidth'(t_ff);
            k_sel = absm_ff + ArgWidth'(t_ff);
         end
         SEL_T_U: begin
            n_sel = ArgWidth'(t_ff);
            k_sel = ArgWidth'(u_ff);
         end
         default: begin
            n_sel = absm_ff;
            k_sel = {1'b0, v_ff, neg_ff};
         end
      endcase
   end

   // Table lookup with symmetry folding; k above n gives zero.
   always_comb begin
      n_minus_k = n_sel - k_sel;
      k_fold    = (k_sel > n_minus_k) ? n_minus_k : k_sel;
      if (k_sel > n_sel) begin
         bin = '0;
      end else begin
         bin = BinomTable[n_sel][k_fold[ColWidth-1:0]];
      end
   end

   assign prod_a  = acc_a_ff[BinomWidth-1:0] * bin;
   assign prod_b  = acc_b_ff[BinomWidth-1:0] * bin;
   assign prod_ab = acc_a_ff[ProdWidth-1:0] * acc_b_ff;

   // Accumulator updates under microcode control.
   always_comb begin
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      unique case (ctrl.op)
         OP_CLEAR_A: acc_a_in = '0;
         OP_LOAD_A:  acc_a_in = MagWidth'(bin);
         OP_MUL_A:   acc_a_in = MagWidth'(prod_a);
         OP_LOAD_B:  acc_b_in = ProdWidth'(bin);
         OP_MUL_B:   acc_b_in = prod_b;
         OP_MUL_AB:  acc_a_in = prod_ab[MagWidth-1:0];
         default: begin
            acc_a_in = acc_a_ff;
            acc_b_in = acc_b_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      l_ff     <= l_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      neg_ff   <= neg_in;
      absm_ff  <= absm_in;
      bad_ff   <= bad_in;
      acc_a_ff <= acc_a_in;
      acc_b_ff <= acc_b_in;
   end

   assign magnitude   = acc_a_ff;
   assign shift_count = {t_ff, 1'b0};
   assign bad         = bad_ff;

endmodule

// File: rtl/core/solid_harmonic_c_coefficient.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    ang_l, order_m, index_t, index_u, index_v
// rsp_      out        rsp_valid/stall    coeff_magnitude, shift_count, out_of_range
//
// A transaction runs a seven-step microprogram on one binomial table and three multipliers;
// the next request is taken only after it ends, and when t > l the clear step jumps to the final step.
// The step counter walks the program; the final step waits only if the result register
// is still held by a stalled consumer, so the next request is taken while a result waits.
// Synchronous reset empties the sequencer and the result register.
module solid_harmonic_c_coefficient
   import shcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [LWidth-1:0]        req_ang_l,
   input  logic signed [MWidth-1:0] req_order_m,
   input  logic [TWidth-1:0]        req_index_t,
   input  logic [UWidth-1:0]        req_index_u,
   input  logic [VWidth-1:0]        req_index_v,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [MagWidth-1:0]      rsp_coeff_magnitude,
   output logic [ShiftWidth-1:0]    rsp_shift_count,
   output logic                     rsp_out_of_range
);

   logic      busy_ff, busy_in;
   step_type  pc_ff, pc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [MagWidth-1:0]   rsp_mag_ff, rsp_mag_in;
   logic [ShiftWidth-1:0] rsp_shift_ff, rsp_shift_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   logic                  req_accept, out_free, finish;
   uword_type             uword;
   ctrl_type              ctrl;
   logic [MagWidth-1:0]   dp_mag;
   logic [ShiftWidth-1:0] dp_shift;
   logic                  dp_bad;

   assign req_accept = req_valid && !busy_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign uword      = ucode_rom(pc_ff);
   assign finish     = busy_ff && (uword.ctrl.op == OP_DONE) && out_free;

   // Only a running program drives the datapath.
   always_comb begin
      if (busy_ff) begin
         ctrl = uword.ctrl;
      end else begin
         ctrl = '{op: OP_HOLD, sel: SEL_L_T};
      end
   end

   // Step counter with conditional jump.
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (req_accept) begin
         busy_in = 1'b1;
         pc_in   = StepFirst;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff && uword.ctrl.op != OP_DONE) begin
         if (uword.jmp == JMP_BAD && dp_bad) begin
            pc_in = uword.target;
         end else begin
            pc_in = pc_ff + step_type'(1);
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mag_in   = rsp_mag_ff;
      rsp_shift_in = rsp_shift_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_mag_in   = dp_mag;
         rsp_shift_in = dp_shift;
         rsp_bad_in   = dp_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= StepFirst;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_mag_ff   <= rsp_mag_in;
      rsp_shift_ff <= rsp_shift_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   shcc_datapath u_datapath (
      .clock       (clock),
      .load        (req_accept),
      .ang_l       (req_ang_l),
      .order_m     (req_order_m),
      .index_t     (req_index_t),
      .index_u     (req_index_u),
      .index_v     (req_index_v),
      .ctrl        (ctrl),
      .magnitude   (dp_mag),
      .shift_count (dp_shift),
      .bad         (dp_bad)
   );

   assign req_stall           = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coeff_magnitude = rsp_mag_ff;
   assign rsp_shift_count     = rsp_shift_ff;
   assign rsp_out_of_range    = rsp_bad_ff;

endmodule

// File: rtl/core/shcc_checker.sv
module shcc_checker
   import shcc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [LWidth-1:0]        req_ang_l,
   input logic signed [MWidth-1:0] req_order_m,
   input logic [TWidth-1:0]        req_index_t,
   input logic [UWidth-1:0]        req_index_u,
   input logic [VWidth-1:0]        req_index_v,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [MagWidth-1:0]      rsp_coeff_magnitude,
   input logic [ShiftWidth-1:0]    rsp_shift_count,
   input logic                     rsp_out_of_range
);

   // An accepted request occupies the sequencer for the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer not busy after an accepted request");

   // A stalled request keeps its payload until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable({req_ang_l, req_order_m, req_index_t,
                                                      req_index_u, req_index_v}))
      else $error("stalled request changed");

   // A result flagged out of range carries a zero magnitude.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_coeff_magnitude == '0)
      else $error("out-of-range result with non-zero magnitude");

   // The shift count is always twice t, hence even.
   a_shift_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_shift_count[0])
      else $error("odd shift count");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coeff_magnitude))
      else $error("stalled result changed");

endmodule

bind solid_harmonic_c_coefficient shcc_checker u_shcc_checker (.*);

// File: test/solid_harmonic_c_coefficient_tb.sv
module solid_harmonic_c_coefficient_tb
   import shcc_pkg::*;
();

   // One request transaction as the sender holds it.
   typedef struct {
      logic [LWidth-1:0]        ang_l;
      logic signed [MWidth-1:0] order_m;
      logic [TWidth-1:0]        index_t;
      logic [UWidth-1:0]        index_u;
      logic [VWidth-1:0]        index_v;
      bit                       drain_first;
   } harmonic_request_type;

   // One response transaction.
   typedef struct packed {
      logic [MagWidth-1:0]   magnitude;
      logic [ShiftWidth-1:0] shift;
      logic                  out_of_range;
   } coeff_result_type;

   localparam int RandomRequests = 650;
   localparam int SettleCycles   = 20;
   localparam int LargestL       = 15;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [LWidth-1:0]        req_ang_l = '0;
   logic signed [MWidth-1:0] req_order_m = '0;
   logic [TWidth-1:0]        req_index_t = '0;
   logic [UWidth-1:0]        req_index_u = '0;
   logic [VWidth-1:0]        req_index_v = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [MagWidth-1:0]      rsp_coeff_magnitude;
   logic [ShiftWidth-1:0]    rsp_shift_count;
   logic                     rsp_out_of_range;

   harmonic_request_type pending_requests[$];
   coeff_result_type     coeff_expected[$];
   harmonic_request_type held_request;
   int                   total_requests = 0;
   int                   requests_sent = 0;
   int                   mismatches = 0;

   solid_harmonic_c_coefficient i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_ang_l           (req_ang_l),
      .req_order_m         (req_order_m),
      .req_index_t         (req_index_t),
      .req_index_u         (req_index_u),
      .req_index_v         (req_index_v),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_coeff_magnitude (rsp_coeff_magnitude),
      .rsp_shift_count     (rsp_shift_count),
      .rsp_out_of_range    (rsp_out_of_range)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact binomial coefficient; zero when k exceeds n.
   function automatic longint unsigned binomial(int unsigned n, int unsigned k);
      longint unsigned r;
      r = 1;
      if (k > n) begin
         return 0;
      end
      if (k > n - k) begin
         k = n - k;
      end
      for (int unsigned i = 1; i <= k; i++) begin
         r = r * (n - k + i) / i;
      end
      return r;
   endfunction

   // Product of the four binomials, the 2t shift and the range flag for one request.
   function automatic coeff_result_type expected_coefficient(harmonic_request_type rq);
      coeff_result_type res;
      int unsigned      l;
      int unsigned      t;
      int unsigned      m_raw;
      int unsigned      abs_m;
      bit               sine_part;
      longint unsigned  product;
      l         = rq.ang_l;
      t         = rq.index_t;
      m_raw     = int'($unsigned(rq.order_m));
      sine_part = rq.order_m[MWidth-1];
      abs_m     = sine_part ? (32 - m_raw) : m_raw;
      product   = 0;
      res.out_of_range = 1'b0;
      if (t > l || l > LargestL) begin
         res.out_of_range = 1'b1;
      end else begin
         product = binomial(l, t) * binomial(l - t, abs_m + t) * binomial(t, rq.index_u)
                   * binomial(abs_m, 2 * rq.index_v + (sine_part ? 1 : 0));
      end
      res.magnitude = product[MagWidth-1:0];
      res.shift     = ShiftWidth'(2 * t);
      return res;
   endfunction

   function automatic harmonic_request_type make_request(int l, int m, int t, int u, int v);
      harmonic_request_type rq;
      rq.ang_l       = LWidth'(l);
      rq.order_m     = MWidth'(m);
      rq.index_t     = TWidth'(t);
      rq.index_u     = UWidth'(u);
      rq.index_v     = VWidth'(v);
      rq.drain_first = 1'b0;
      return rq;
   endfunction

   // A request whose four binomials are all non-zero.
   function automatic harmonic_request_type valid_request();
      int l;
      int t;
      int abs_m;
      int neg;
      int v;
      l     = $urandom_range(LargestL);
      t     = $urandom_range(l / 2);
      abs_m = $urandom_range(l - 2 * t);
      neg   = (abs_m > 0) ? $urandom_range(1) : 0;
      v     = neg ? $urandom_range((abs_m - 1) / 2) : $urandom_range(abs_m / 2);
      return make_request(l, neg ? -abs_m : abs_m, t, $urandom_range(t), v);
   endfunction

   // Idle percentage of either side; the run passes through three mixes.
   function automatic int idle_percent(bit sender);
      if (requests_sent * 3 < total_requests) begin
         return sender ? 19 : 65;
      end else if (requests_sent * 3 < total_requests * 2) begin
         return sender ? 65 : 19;
      end
      return 0;
   endfunction

   // Driver: presents the head of the queue and records its prediction on acceptance.
   always @(posedge clock) begin : request_driver
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            coeff_expected.push_back(expected_coefficient(held_request));
            void'(pending_requests.pop_front());
            requests_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_requests.size() != 0) begin
            if (!(pending_requests[0].drain_first && coeff_expected.size() != 0) &&
                $urandom_range(99) >= idle_percent(1'b1)) begin
               held_request = pending_requests[0];
               next_valid   = 1'b1;
               req_ang_l   <= held_request.ang_l;
               req_order_m <= held_request.order_m;
               req_index_t <= held_request.index_t;
               req_index_u <= held_request.index_u;
               req_index_v <= held_request.index_v;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: compares each accepted response transaction with the oldest prediction.
   always @(posedge clock) begin : response_monitor
      coeff_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coeff_expected.size() == 0) begin
            $display("%0t: unexpected response, magnitude %0d shift %0d flag %0b", $time,
                     rsp_coeff_magnitude, rsp_shift_count, rsp_out_of_range);
            mismatches++;
         end else begin
            want = coeff_expected.pop_front();
            if (rsp_coeff_magnitude !== want.magnitude) begin
               $display("%0t: coeff_magnitude expected %0d, actual %0d", $time,
                        want.magnitude, rsp_coeff_magnitude);
               mismatches++;
            end
            if (rsp_shift_count !== want.shift) begin
               $display("%0t: shift_count expected %0d, actual %0d", $time,
                        want.shift, rsp_shift_count);
               mismatches++;
            end
            if (rsp_out_of_range !== want.out_of_range) begin
               $display("%0t: out_of_range expected %0b, actual %0b", $time,
                        want.out_of_range, rsp_out_of_range);
               mismatches++;
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < idle_percent(1'b0));
   end

   // Stimulus: directed corner cases, then mostly well-formed random requests.
   initial begin : stimulus
      harmonic_request_type rq;
      // Zero inputs and the largest l with trivial indices.
      pending_requests.push_back(make_request(0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(15, 0, 0, 0, 0));
      // Larger products, with t at l/2 rounded down.
      pending_requests.push_back(make_request(15, 0, 7, 3, 0));
      pending_requests.push_back(make_request(15, 1, 7, 3, 0));
      pending_requests.push_back(make_request(14, 0, 7, 4, 0));
      pending_requests.push_back(make_request(8, 0, 4, 2, 0));
      // Index t above l raises the flag and still reports the shift.
      pending_requests.push_back(make_request(3, 0, 9, 1, 0));
      pending_requests.push_back(make_request(0, 0, 15, 0, 0));
      pending_requests.push_back(make_request(14, 2, 15, 7, 3));
      // Order of minus sixteen makes the second binomial zero.
      pending_requests.push_back(make_request(15, -16, 0, 0, 0));
      pending_requests.push_back(make_request(0, -16, 0, 0, 7));
      // Orders up to fifteen in size, cosine and sine parts.
      pending_requests.push_back(make_request(15, 15, 0, 0, 7));
      pending_requests.push_back(make_request(15, -15, 0, 0, 7));
      pending_requests.push_back(make_request(15, 15, 0, 0, 0));
      pending_requests.push_back(make_request(1, -1, 0, 0, 0));
      pending_requests.push_back(make_request(13, -13, 0, 0, 6));
      // A binomial with k above n in the second, third and fourth positions.
      pending_requests.push_back(make_request(6, 0, 2, 5, 0));
      pending_requests.push_back(make_request(10, 2, 1, 0, 3));
      pending_requests.push_back(make_request(5, 4, 2, 1, 0));
      pending_requests.push_back(make_request(4, -2, 0, 0, 1));
      pending_requests.push_back(make_request(15, 0, 15, 15, 7));
      // All input bits set.
      pending_requests.push_back(make_request(15, -1, 15, 15, 7));
      for (int i = 0; i < RandomRequests; i++) begin
         if ($urandom_range(3) != 0) begin
            rq = valid_request();
         end else begin
            rq = make_request($urandom, $urandom, $urandom, $urandom, $urandom);
         end
         // Let the block drain completely before the random part and once midway.
         rq.drain_first = (i == 0) || (i == RandomRequests / 2);
         pending_requests.push_back(rq);
      end
      total_requests = pending_requests.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || coeff_expected.size() != 0);
      repeat (SettleCycles) @(posedge clock);

      if (mismatches == 0 && coeff_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
